[sv/rtfq_pkg.sv]
// ----------------------------------------------------------------------------
// rtfq_pkg
// Shared types and constants for the refcounted task fan-out queue.
// ----------------------------------------------------------------------------
package rtfq_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int MAX_CPUS   = 8;
    localparam int NUM_LEVELS = 3;
    localparam int NUM_HEADS  = NUM_LEVELS * MAX_CPUS;
    localparam int SLOT_W     = 7;
    localparam int IDX_W      = 6;
    localparam int CPU_W      = 3;
    localparam int HEAD_W     = 5;
    localparam int LINK_W     = IDX_W + CPU_W;

    localparam logic [7:0] VEC_DPC = 8'h2F;
    localparam logic [7:0] VEC_IPI = 8'hE1;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_QUEUE   = 2'd2;
    localparam logic [1:0] OP_SERVICE = 2'd3;

    localparam logic [1:0] TGT_ONE  = 2'd0;
    localparam logic [1:0] TGT_ABS  = 2'd1;
    localparam logic [1:0] TGT_ALL  = 2'd2;
    localparam logic [1:0] TGT_SELF = 2'd3;

    localparam logic [1:0] LVL_DPC = 2'd0;
    localparam logic [1:0] LVL_IPI = 2'd1;
    localparam logic [1:0] LVL_NMI = 2'd2;

    localparam logic [1:0] REG_CPU_COUNT = 2'd0;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] task_slot;
        logic [1:0] level;
        logic [1:0] target;
        logic [2:0] dest_cpu;
        logic [2:0] self_cpu;
        logic       single_run;
    } in_item_t;

    typedef struct packed {
        logic [6:0] slot_out;
        logic       run_task;
        logic       slot_freed;
        logic       full_flag;
        logic       list_empty;
        logic [7:0] irq_vector;
        logic       nmi_mode;
        logic       send_irq;
        logic [2:0] irq_dest;
        logic       last_result;
    } out_item_t;

endpackage

[sv/rtfq_ram.sv]
// ----------------------------------------------------------------------------
// rtfq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module rtfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/refcounted_task_fanout_queue.sv]
// Flow: allocate goes from S_IDLE to S_EMIT, release through S_DISPATCH, queue
//   through S_DISPATCH and one S_QLINK step per linked cpu list, service through
//   S_DISPATCH, then S_SRD and S_SEMIT per task walked (one link read each).
// Throughput: one item at a time; the next item is accepted once the last
//   result beat of the current one has been loaded into the output register.
// Reset: occupancy bitmap and list heads clear at once (flip-flops), cpu_count
//   returns to 1; the per-slot memories need no clearing pass.
// ----------------------------------------------------------------------------
// refcounted_task_fanout_queue
// Slot allocator with reference counts and per-cpu, per-level task lists.
// ----------------------------------------------------------------------------
module refcounted_task_fanout_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rtfq_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rtfq_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rtfq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_QLINK, S_SRD, S_SEMIT, S_EMIT
    } state_t;

    // slot data memory: {ref_count, pending, run_threshold}
    logic             sd_we;
    logic [IDX_W-1:0] sd_waddr, sd_raddr;
    logic [23:0]      sd_wdata, sd_rdata;
    // link memory, addressed by {slot index, cpu}
    logic              ln_we;
    logic [LINK_W-1:0] ln_waddr, ln_raddr;
    logic [SLOT_W-1:0] ln_wdata, ln_rdata;

    rtfq_ram #(.WIDTH(24), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .clk(clk), .we(sd_we), .waddr(sd_waddr), .wdata(sd_wdata),
        .raddr(sd_raddr), .rdata(sd_rdata)
    );
    rtfq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT * MAX_CPUS)) u_link_ram (
        .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
        .raddr(ln_raddr), .rdata(ln_rdata)
    );

    state_t            state_reg;
    in_item_t          item_reg;
    logic [SLOT_COUNT-1:0] occ_reg;
    logic [SLOT_W-1:0] head_reg [NUM_HEADS];
    logic [3:0]        cpu_count_reg;
    logic [MAX_CPUS-1:0] mask_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SLOT_W-1:0] walk_reg;      // current task in service walk
    logic [IDX_W:0]    walk_cnt_reg;  // entries emitted so far
    logic              out_valid_reg;
    out_item_t         out_reg;
    out_item_t         pend_reg;      // result waiting for output register

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == REG_CPU_COUNT) ? {28'd0, cpu_count_reg} : 32'd0;
    wire cfg_wr = psel && penable && pwrite;

    // ---------------- helpers ----------------
    wire out_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    wire in_acc = in_valid && !in_stall;

    // lowest free slot
    logic [IDX_W-1:0] free_idx;
    logic             free_found;
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
            begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    wire [SLOT_W-1:0] slot = item_reg.task_slot;
    wire slot_ok = (slot >= SLOT_W'(1)) && (slot <= SLOT_W'(SLOT_COUNT))
                   && occ_reg[idx_reg];
    wire [3:0] eff = (cpu_count_reg > 4'(MAX_CPUS)) ? 4'(MAX_CPUS) : cpu_count_reg;

    logic [MAX_CPUS-1:0] qmask;
    always_comb
    begin
        qmask = '0;
        case (item_reg.target)
            TGT_ONE:  qmask[item_reg.dest_cpu] = 1'b1;
            TGT_SELF: qmask[item_reg.self_cpu] = 1'b1;
            default:
            begin
                for (int n = 0; n < MAX_CPUS; n++)
                begin
                    if ((4'(n) < eff) && ((item_reg.target == TGT_ALL)
                        || (3'(n) != item_reg.self_cpu)))
                    begin
                        qmask[n] = 1'b1;
                    end
                end
            end
        endcase
    end
    wire [7:0] qcount = 8'($countones(qmask));

    logic [CPU_W-1:0] low_cpu;
    always_comb
    begin
        low_cpu = '0;
        for (int n = MAX_CPUS - 1; n >= 0; n--)
        begin
            if (mask_reg[n])
            begin
                low_cpu = CPU_W'(n);
            end
        end
    end

    wire [HEAD_W-1:0] svc_h = HEAD_W'(item_reg.level) * HEAD_W'(MAX_CPUS)
                              + HEAD_W'(item_reg.self_cpu);
    wire [HEAD_W-1:0] q_h = HEAD_W'(item_reg.level) * HEAD_W'(MAX_CPUS)
                            + HEAD_W'(low_cpu);

    wire [7:0] rd_ref = sd_rdata[23:16];
    wire [7:0] rd_pend = sd_rdata[15:8];
    wire [7:0] rd_thr = sd_rdata[7:0];
    wire [IDX_W-1:0] walk_idx = IDX_W'(walk_reg - SLOT_W'(1));

    // memory drive
    always_comb
    begin
        sd_we = 1'b0; sd_waddr = idx_reg; sd_wdata = sd_rdata; sd_raddr = idx_reg;
        ln_we = 1'b0; ln_waddr = {idx_reg, low_cpu}; ln_wdata = '0;
        ln_raddr = {walk_idx, item_reg.self_cpu};
        case (state_reg)
            S_DISPATCH:
            begin
                if (item_reg.op == OP_RELEASE && slot_ok)
                begin
                    sd_we = 1'b1;
                    sd_wdata = {rd_ref - 8'd1, rd_pend, rd_thr};
                end
                else if (item_reg.op == OP_QUEUE && slot_ok && rd_pend == 8'd0
                         && item_reg.level != 2'd3 && qcount != 8'd0)
                begin
                    sd_we = 1'b1;
                    sd_wdata = {rd_ref + qcount, qcount,
                                ((item_reg.target == TGT_ABS
                                  || item_reg.target == TGT_ALL)
                                 && item_reg.single_run) ? qcount - 8'd1 : 8'd0};
                end
            end
            S_QLINK:
            begin
                ln_we = 1'b1;
                ln_wdata = head_reg[q_h];
            end
            S_SRD:
            begin
                sd_raddr = walk_idx;
            end
            S_SEMIT:
            begin
                sd_raddr = walk_idx;
                sd_waddr = walk_idx;
                if (occ_reg[walk_idx] && out_free)
                begin
                    sd_we = 1'b1;
                    sd_wdata = {rd_ref - 8'd1, rd_pend - 8'd1, rd_thr};
                end
            end
            default:
            begin
                if (state_reg == S_IDLE && in_acc && in_data.op == OP_ALLOC
                    && free_found)
                begin
                    sd_we = 1'b1; sd_waddr = free_idx;
                    sd_wdata = {8'd1, 8'd0, 8'd0};
                end
                if (state_reg == S_IDLE)
                begin
                    sd_raddr = IDX_W'(in_data.task_slot - SLOT_W'(1));
                end
            end
        endcase
    end

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        out_item_t r;
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            cpu_count_reg <= 4'd1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_HEADS; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr && paddr == REG_CPU_COUNT)
            begin
                cpu_count_reg <= pwdata[3:0];
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            r = '0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        item_reg <= in_data;
                        idx_reg  <= IDX_W'(in_data.task_slot - SLOT_W'(1));
                        if (in_data.op == OP_ALLOC)
                        begin
                            r.last_result = 1'b1;
                            if (free_found)
                            begin
                                occ_reg[free_idx] <= 1'b1;
                                r.slot_out = SLOT_W'(free_idx) + SLOT_W'(1);
                            end
                            else
                            begin
                                r.full_flag = 1'b1;
                            end
                            pend_reg  <= r;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_DISPATCH;
                        end
                    end
                end
                S_DISPATCH:
                begin
                    r.last_result = 1'b1;
                    state_reg <= S_EMIT;
                    case (item_reg.op)
                        OP_RELEASE:
                        begin
                            if (slot_ok)
                            begin
                                r.slot_out = slot;
                                if (rd_ref == 8'd1)
                                begin
                                    r.slot_freed = 1'b1;
                                    occ_reg[idx_reg] <= 1'b0;
                                end
                            end
                        end
                        OP_QUEUE:
                        begin
                            if (slot_ok && rd_pend == 8'd0 && item_reg.level != 2'd3)
                            begin
                                r.slot_out = slot;
                                if (qcount != 8'd0)
                                begin
                                    r.irq_vector = (item_reg.level == LVL_DPC) ? VEC_DPC :
                                        (item_reg.level == LVL_IPI) ? VEC_IPI : 8'd0;
                                    r.nmi_mode = (item_reg.level == LVL_NMI);
                                    r.send_irq = 1'b1;
                                    r.irq_dest = (item_reg.target == TGT_ONE)
                                                 ? item_reg.dest_cpu : 3'd0;
                                    mask_reg  <= qmask;
                                    state_reg <= S_QLINK;
                                end
                            end
                        end
                        default:
                        begin
                            if (item_reg.level == 2'd3 || head_reg[svc_h] == '0
                                || head_reg[svc_h] > SLOT_W'(SLOT_COUNT))
                            begin
                                r.list_empty = 1'b1;
                                if (item_reg.level != 2'd3)
                                begin
                                    head_reg[svc_h] <= '0;
                                end
                            end
                            else
                            begin
                                walk_reg     <= head_reg[svc_h];
                                head_reg[svc_h] <= '0;
                                walk_cnt_reg <= '0;
                                state_reg    <= S_SRD;
                            end
                        end
                    endcase
                    pend_reg <= r;
                end
                S_QLINK:
                begin
                    head_reg[q_h] <= slot;
                    mask_reg[low_cpu] <= 1'b0;
                    if (mask_reg == (MAX_CPUS'(1) << low_cpu))
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_SRD:
                begin
                    state_reg <= S_SEMIT;
                end
                S_SEMIT:
                begin
                    if (out_free)
                    begin
                        r.slot_out = walk_reg;
                        if (occ_reg[walk_idx])
                        begin
                            r.run_task = (rd_pend - 8'd1) >= rd_thr;
                            if (rd_ref == 8'd1)
                            begin
                                r.slot_freed = 1'b1;
                                occ_reg[walk_idx] <= 1'b0;
                            end
                        end
                        walk_reg     <= ln_rdata;
                        walk_cnt_reg <= walk_cnt_reg + 1'b1;
                        if (ln_rdata == '0 || ln_rdata > SLOT_W'(SLOT_COUNT)
                            || walk_cnt_reg == (IDX_W+1)'(SLOT_COUNT - 1))
                        begin
                            r.last_result = 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_SRD;
                        end
                        out_reg       <= r;
                        out_valid_reg <= 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg       <= pend_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // While SEMIT waits on the output, both read addresses stay on walk_reg and
    // the write-back waits for the beat to leave, so the read data holds.

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input accepted while busy");
    a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.slot_freed && !out_stall) |-> out_data.slot_out != '0)
        else $error("freed result without slot");
    a_alloc_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_acc && in_data.op == OP_ALLOC && free_found)
        |=> occ_reg[$past(free_idx)])
        else $error("allocated slot not marked occupied");
endmodule

[dv/rtfq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfq_checker
// Watches the item, result and register ports of the task fan-out queue,
// keeps its own copy of the slot pool and per-cpu lists, and compares every
// result beat with the expected one.
// ----------------------------------------------------------------------------
module rtfq_checker
    import rtfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fails,
    output int          outstanding,
    output int          beats_seen
);

    logic [3:0] cpu_cnt;
    logic       occ    [SLOT_COUNT];
    logic [7:0] refs   [SLOT_COUNT];
    logic [7:0] pend   [SLOT_COUNT];
    logic [7:0] thresh [SLOT_COUNT];
    logic [6:0] heads  [NUM_HEADS];
    logic [6:0] links  [SLOT_COUNT*MAX_CPUS];
    out_item_t  want_q [$];

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fails++;
    endtask

    task automatic chk(input string f, input int got, input int exp);
        if (got != exp)
            report($sformatf("%s got %0d expected %0d", f, got, exp));
    endtask

    function automatic logic drop_ref(input int idx);
        refs[idx] = refs[idx] - 8'd1;
        if (refs[idx] == 8'd0)
        begin
            occ[idx] = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Works out every result beat of one item and updates the pool.
    task automatic predict_task_op(input in_item_t it);
        out_item_t  r;
        int         idx;
        int         eff;
        int         cnt;
        int         k;
        logic [7:0] mask;
        logic [6:0] cur;
        logic       ok;
        r = '0;
        r.last_result = 1'b1;
        idx = int'(it.task_slot) - 1;
        ok = it.task_slot >= 1 && it.task_slot <= SLOT_COUNT;
        if (ok)
            ok = occ[idx];
        case (it.op)
            OP_ALLOC:
            begin
                r.full_flag = 1'b1;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!occ[i])
                    begin
                        occ[i] = 1'b1;
                        refs[i] = 8'd1;
                        pend[i] = 8'd0;
                        thresh[i] = 8'd0;
                        r.slot_out = 7'(i + 1);
                        r.full_flag = 1'b0;
                        break;
                    end
                end
                want_q.push_back(r);
            end
            OP_RELEASE:
            begin
                if (ok)
                begin
                    r.slot_out = it.task_slot;
                    r.slot_freed = drop_ref(idx);
                end
                want_q.push_back(r);
            end
            OP_QUEUE:
            begin
                if (ok && it.level < NUM_LEVELS && pend[idx] == 8'd0)
                begin
                    eff = cpu_cnt > MAX_CPUS ? MAX_CPUS : int'(cpu_cnt);
                    mask = '0;
                    if (it.target == TGT_ONE)
                        mask[it.dest_cpu] = 1'b1;
                    else if (it.target == TGT_SELF)
                        mask[it.self_cpu] = 1'b1;
                    else
                        for (int n = 0; n < eff; n++)
                            if (it.target == TGT_ALL || n != it.self_cpu)
                                mask[n] = 1'b1;
                    cnt = $countones(mask);
                    r.slot_out = it.task_slot;
                    if (cnt != 0)
                    begin
                        pend[idx] = 8'(cnt);
                        refs[idx] = refs[idx] + 8'(cnt);
                        thresh[idx] = ((it.target == TGT_ABS || it.target == TGT_ALL)
                                       && it.single_run) ? 8'(cnt - 1) : 8'd0;
                        for (int n = 0; n < MAX_CPUS; n++)
                        begin
                            if (mask[n])
                            begin
                                links[idx*MAX_CPUS + n] = heads[it.level*MAX_CPUS + n];
                                heads[it.level*MAX_CPUS + n] = it.task_slot;
                            end
                        end
                        r.irq_vector = it.level == LVL_DPC ? VEC_DPC :
                                       (it.level == LVL_IPI ? VEC_IPI : 8'd0);
                        r.nmi_mode = it.level == LVL_NMI;
                        r.send_irq = 1'b1;
                        r.irq_dest = it.target == TGT_ONE ? it.dest_cpu : 3'd0;
                    end
                end
                want_q.push_back(r);
            end
            default:
            begin
                if (it.level >= NUM_LEVELS)
                    cur = '0;
                else
                begin
                    cur = heads[it.level*MAX_CPUS + it.self_cpu];
                    heads[it.level*MAX_CPUS + it.self_cpu] = '0;
                end
                if (cur == 0 || cur > SLOT_COUNT)
                begin
                    r.list_empty = 1'b1;
                    want_q.push_back(r);
                end
                else
                begin
                    k = 0;
                    while (cur != 0 && cur <= SLOT_COUNT && k < SLOT_COUNT)
                    begin
                        r = '0;
                        r.slot_out = cur;
                        idx = int'(cur) - 1;
                        cur = links[idx*MAX_CPUS + it.self_cpu];
                        if (occ[idx])
                        begin
                            pend[idx] = pend[idx] - 8'd1;
                            r.run_task = pend[idx] >= thresh[idx];
                            r.slot_freed = drop_ref(idx);
                        end
                        k++;
                        r.last_result = !(cur != 0 && cur <= SLOT_COUNT
                                          && k < SLOT_COUNT);
                        want_q.push_back(r);
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            cpu_cnt = 4'd1;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                occ[i] = 1'b0;
                refs[i] = '0;
                pend[i] = '0;
                thresh[i] = '0;
            end
            for (int i = 0; i < NUM_HEADS; i++)
                heads[i] = '0;
            for (int i = 0; i < SLOT_COUNT*MAX_CPUS; i++)
                links[i] = '0;
            want_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == 2'(4*REG_CPU_COUNT))
                cpu_cnt = pwdata[3:0];
            if (in_valid && !in_stall)
                predict_task_op(in_data);
            if (out_valid && !out_stall)
            begin
                beats_seen++;
                if (want_q.size() == 0)
                    report("result beat with nothing expected");
                else
                begin
                    e = want_q.pop_front();
                    chk("slot_out", out_data.slot_out, e.slot_out);
                    chk("run_task", out_data.run_task, e.run_task);
                    chk("slot_freed", out_data.slot_freed, e.slot_freed);
                    chk("full_flag", out_data.full_flag, e.full_flag);
                    chk("list_empty", out_data.list_empty, e.list_empty);
                    chk("irq_vector", out_data.irq_vector, e.irq_vector);
                    chk("nmi_mode", out_data.nmi_mode, e.nmi_mode);
                    chk("send_irq", out_data.send_irq, e.send_irq);
                    chk("irq_dest", out_data.irq_dest, e.irq_dest);
                    chk("last_result", out_data.last_result, e.last_result);
                end
            end
        end
        outstanding = want_q.size();
    end

    initial
    begin
        fails = 0;
        beats_seen = 0;
        outstanding = 0;
    end

endmodule

[dv/refcounted_task_fanout_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_task_fanout_queue_tb
// Drives allocate / release / queue / service items under several cpu counts,
// with random idle bursts on both sides and one long output hold-off; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module refcounted_task_fanout_queue_tb;
    import rtfq_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fails;
    int          outstanding;
    int          beats_seen;
    int          items_sent;
    int          cycles;
    logic        calm;      // no idling at either side
    logic        hold_req;  // ask the result side for one long hold-off

    refcounted_task_fanout_queue i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rtfq_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fails      (fails),
        .outstanding(outstanding),
        .beats_seen (beats_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: short random stall bursts, one long hold-off on request.
    // The long one keeps the block's output full so the sender gets stalled.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (80) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // One beat on the item channel; entered and left at a falling edge.
    task automatic push_beat(input in_item_t it);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Register write, only while the block has nothing in flight.
    task automatic write_cpu_count(input logic [3:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(4*REG_CPU_COUNT);
        pwdata  <= {28'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic in_item_t mk(input logic [1:0] op, input logic [6:0] s,
                                    input logic [1:0] lv, input logic [1:0] tg,
                                    input logic [2:0] d, input logic [2:0] me,
                                    input logic sr);
        in_item_t it;
        it.op = op;
        it.task_slot = s;
        it.level = lv;
        it.target = tg;
        it.dest_cpu = d;
        it.self_cpu = me;
        it.single_run = sr;
        return it;
    endfunction

    // Random item. alloc_pct biases toward allocation (pool filling).
    // Slots are mostly low numbers, since allocation hands out the lowest free.
    function automatic in_item_t rand_item(input int alloc_pct);
        in_item_t   it;
        int         pick;
        logic [6:0] s;
        it = in_item_t'($urandom);
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            s = 7'($urandom_range(0, 127));
        else
            s = 7'($urandom_range(1, alloc_pct > 50 ? 64 : 12));
        it.task_slot = s;
        if ($urandom_range(0, 9) != 0)
            it.level = 2'($urandom_range(0, 2));
        if (pick < alloc_pct)
            it.op = OP_ALLOC;
        else if (pick < alloc_pct + (100 - alloc_pct) / 6)
            it.op = OP_RELEASE;
        else if (pick < alloc_pct + (100 - alloc_pct) * 3 / 5)
            it.op = OP_QUEUE;
        else
            it.op = OP_SERVICE;
        return it;
    endfunction

    task automatic run_random(input int n, input int alloc_pct);
        repeat (n) push_beat(rand_item(alloc_pct));
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        calm     = 1'b0;
        hold_req = 1'b0;
        items_sent = 0;
        cycles   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_cpu_count(4'd8);

        // Directed: slots 1..3, bad slots, every target and level, one-shot
        // fan-out, requeue while pending, level 3, empty and full lists.
        push_beat(mk(OP_ALLOC, 0, 0, 0, 0, 0, 0));
        push_beat(mk(OP_ALLOC, 0, 0, 0, 0, 0, 0));
        push_beat(mk(OP_ALLOC, 0, 0, 0, 0, 0, 0));
        push_beat(mk(OP_RELEASE, 7'd0, 0, 0, 0, 0, 0));
        push_beat(mk(OP_RELEASE, 7'd64, 0, 0, 0, 0, 0));
        push_beat(mk(OP_RELEASE, 7'd127, 0, 0, 0, 0, 0));
        push_beat(mk(OP_QUEUE, 7'd1, LVL_DPC, TGT_ALL, 3'd0, 3'd0, 1'b1));
        push_beat(mk(OP_QUEUE, 7'd1, LVL_DPC, TGT_ALL, 3'd0, 3'd0, 1'b1));
        push_beat(mk(OP_QUEUE, 7'd2, LVL_IPI, TGT_ABS, 3'd0, 3'd7, 1'b1));
        push_beat(mk(OP_QUEUE, 7'd3, LVL_NMI, TGT_ONE, 3'd7, 3'd0, 1'b0));
        push_beat(mk(OP_QUEUE, 7'd3, 2'd3, TGT_SELF, 3'd0, 3'd5, 1'b0));
        push_beat(mk(OP_SERVICE, 0, LVL_DPC, 0, 0, 3'd0, 0));
        push_beat(mk(OP_SERVICE, 0, LVL_DPC, 0, 0, 3'd1, 0));
        push_beat(mk(OP_SERVICE, 0, LVL_IPI, 0, 0, 3'd7, 0));
        push_beat(mk(OP_SERVICE, 0, 2'd3, 0, 0, 3'd0, 0));
        push_beat(mk(OP_SERVICE, 0, LVL_NMI, 0, 0, 3'd0, 0));
        push_beat(mk(OP_SERVICE, 0, LVL_NMI, 0, 0, 3'd7, 0));
        push_beat(mk(OP_QUEUE, 7'd3, LVL_DPC, TGT_SELF, 3'd0, 3'd5, 1'b0));
        push_beat(mk(OP_SERVICE, 0, LVL_DPC, 0, 0, 3'd5, 0));
        push_beat(mk(OP_RELEASE, 7'd1, 0, 0, 0, 0, 0));
        push_beat(mk(OP_RELEASE, 7'd3, 0, 0, 0, 0, 0));

        write_cpu_count(4'd1);
        run_random(60, 20);

        // Pool filling: mostly allocations, pushing the pool toward the full flag.
        write_cpu_count(4'd15);
        run_random(80, 70);

        // No fan-out processors; queues to all / all-but-self link nothing.
        write_cpu_count(4'd0);
        hold_req = 1'b1;
        run_random(50, 15);

        write_cpu_count(4'd3);
        run_random(40, 20);

        write_cpu_count(4'd8);
        calm = 1'b1;
        run_random(40, 20);
        in_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("covered %0d items and %0d result beats over cpu counts 8, 1, 15, 0, 3",
                 items_sent, beats_seen);
        $display("with a full pool, one-shot fan-out and an 80-cycle output hold-off");
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
